// ===== design/fiep_pkg.sv =====
// fiep_pkg: shared types and constants for the framed input event parser.
// No dependencies; used by the cell, decode and top design files through scoped names.
package fiep_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    REG_HEAD = 2'd0,
    REG_TAIL = 2'd1,
    REG_KBD  = 2'd2
  } reg_idx_t;

  localparam byte_t HEAD_RST = 8'd170;
  localparam byte_t TAIL_RST = 8'd85;
  localparam byte_t KBD_RST  = 8'd1;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_SHIFT = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    byte_t              event_type;
    logic [15:0]        delay;
    byte_t              keycode;
    byte_t              key_flags;
    byte_t              key_modifier;
    byte_t              buttons;
    logic signed [7:0]  wheel;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } event_t;

endpackage

// ===== design/fiep_cell.sv =====
// fiep_cell: one byte of the frame store chain; loads a received byte or
// takes its right neighbor's byte. Depends on fiep_pkg.
module fiep_cell (
  input  logic                clk,
  input  fiep_pkg::cell_ctl_t ctl_i,
  input  fiep_pkg::byte_t     load_i,
  input  fiep_pkg::byte_t     shift_i,
  output fiep_pkg::byte_t     byte_o
);

  fiep_pkg::byte_t byte_r;

  // load wins: the last cell takes the new word in the same cycle the chain moves
  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      byte_r <= load_i;
    end else if (ctl_i.shift) begin
      byte_r <= shift_i;
    end
  end

  assign byte_o = byte_r;

endmodule

// ===== design/fiep_decode.sv =====
// fiep_decode: turns frame bytes 1..9 into a keyboard or mouse event.
// Depends on fiep_pkg.
module fiep_decode (
  input  logic [9:1][7:0]  frame_i,
  input  fiep_pkg::byte_t  kbd_code_i,
  output fiep_pkg::event_t evt_o
);

  always_comb begin
    evt_o            = '0;
    evt_o.event_type = frame_i[1];
    evt_o.delay      = {frame_i[9], frame_i[8]};
    if (frame_i[1] == kbd_code_i) begin
      evt_o.keycode      = frame_i[2];
      evt_o.key_flags    = frame_i[3];
      evt_o.key_modifier = frame_i[4];
    end else begin
      evt_o.buttons = frame_i[2];
      evt_o.wheel   = frame_i[3];
      evt_o.pos_x   = {frame_i[5], frame_i[4]};
      evt_o.pos_y   = {frame_i[7], frame_i[6]};
    end
  end

endmodule

// ===== design/framed_input_event_parser_top.sv =====
// The event appears on out_valid in the cycle after its tail word is accepted.
// Throughput: one word per cycle while framing is in step and no unread event holds back the tail word.
// A wrong tail starts a resync walk through the cell chain, one position per cycle,
// with in_ready low until the walk ends.
// Reset (rst_n low, synchronous) clears the byte count, state, output valid and
// restores the registers; the frame store cells are not cleared.
module framed_input_event_parser_top #(
  parameter int unsigned FRAME_BYTES = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_event_type,
  output logic [15:0]                   out_delay,
  output logic [7:0]                    out_keycode,
  output logic [7:0]                    out_key_flags,
  output logic [7:0]                    out_key_modifier,
  output logic [7:0]                    out_buttons,
  output logic signed [7:0]             out_wheel,
  output logic signed [15:0]            out_pos_x,
  output logic signed [15:0]            out_pos_y,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fiep_pkg::ADDR_W-1:0]   paddr,
  input  logic [fiep_pkg::DATA_W-1:0]   pwdata,
  output logic [fiep_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned STORE_LEN = FRAME_BYTES - 1;
  localparam int unsigned CNT_W     = $clog2(FRAME_BYTES);

  // configuration
  fiep_pkg::byte_t head_r, tail_r, kbd_r;
  logic            cfg_wr;
  fiep_pkg::reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = fiep_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= fiep_pkg::HEAD_RST;
      tail_r <= fiep_pkg::TAIL_RST;
      kbd_r  <= fiep_pkg::KBD_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fiep_pkg::REG_HEAD: head_r <= pwdata[7:0];
        fiep_pkg::REG_TAIL: tail_r <= pwdata[7:0];
        fiep_pkg::REG_KBD:  kbd_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      fiep_pkg::REG_HEAD: prdata[7:0] = head_r;
      fiep_pkg::REG_TAIL: prdata[7:0] = tail_r;
      fiep_pkg::REG_KBD:  prdata[7:0] = kbd_r;
      default:            prdata      = '0;
    endcase
  end

  // control
  fiep_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  fiep_pkg::byte_t  snap_r, snap_nxt;   // head value held for the resync walk
  logic             out_valid_r;
  fiep_pkg::event_t evt_r, evt;

  fiep_pkg::byte_t     cell_q   [STORE_LEN];
  fiep_pkg::cell_ctl_t cell_ctl [STORE_LEN];

  logic full, acc, hit_tail, miss, walk;

  assign full     = (count_r >= CNT_W'(STORE_LEN));
  assign in_ready = (state_r == fiep_pkg::ST_RUN) && (!full || !out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign hit_tail = full && (in_rx_byte == tail_r);
  assign miss     = full && !hit_tail;
  assign walk     = (state_r == fiep_pkg::ST_SHIFT) && (count_r != '0)
                    && (cell_q[0] != snap_r);

  always_comb begin
    for (int i = 0; i < STORE_LEN; i++) begin
      cell_ctl[i].load  = acc && (((count_r == CNT_W'(i)) && (i != 0 || in_rx_byte == head_r))
                                  || (miss && i == STORE_LEN - 1));
      cell_ctl[i].shift = (acc && miss) || walk;
    end
  end

  for (genvar g = 0; g < STORE_LEN; g++) begin : g_cell
    fiep_pkg::byte_t right;
    if (g == STORE_LEN - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_q[g+1];
    end
    fiep_cell u_cell (
      .clk    (clk),
      .ctl_i  (cell_ctl[g]),
      .load_i (in_rx_byte),
      .shift_i(right),
      .byte_o (cell_q[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    snap_nxt  = snap_r;
    unique case (state_r)
      fiep_pkg::ST_RUN: begin
        if (acc) begin
          if (count_r == '0) begin
            if (in_rx_byte == head_r) count_nxt = CNT_W'(1);
          end else if (!full) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (hit_tail) begin
            count_nxt = '0;
          end else begin
            // first position dropped now, the walk continues from there
            count_nxt = CNT_W'(STORE_LEN);
            snap_nxt  = head_r;
            state_nxt = fiep_pkg::ST_SHIFT;
          end
        end
      end
      fiep_pkg::ST_SHIFT: begin
        if (walk) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          state_nxt = fiep_pkg::ST_RUN;
        end
      end
      default: state_nxt = fiep_pkg::ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fiep_pkg::ST_RUN;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    snap_r <= snap_nxt;
  end

  // decode and output register
  logic [9:1][7:0] frame;
  always_comb begin
    for (int i = 1; i <= 9; i++) begin
      frame[i] = cell_q[i];
    end
  end

  fiep_decode u_decode (
    .frame_i   (frame),
    .kbd_code_i(kbd_r),
    .evt_o     (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc && hit_tail) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (acc && hit_tail) begin
      evt_r <= evt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_type   = evt_r.event_type;
  assign out_delay        = evt_r.delay;
  assign out_keycode      = evt_r.keycode;
  assign out_key_flags    = evt_r.key_flags;
  assign out_key_modifier = evt_r.key_modifier;
  assign out_buttons      = evt_r.buttons;
  assign out_wheel        = evt_r.wheel;
  assign out_pos_x        = evt_r.pos_x;
  assign out_pos_y        = evt_r.pos_y;

endmodule

// ===== design/fiep_checker.sv =====
// fiep_checker: port-level assertions for the framed input event parser,
// bound to framed_input_event_parser_top. No package dependency.
module fiep_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [7:0]                  out_event_type,
  input logic [15:0]                 out_delay,
  input logic [7:0]                  out_keycode,
  input logic [7:0]                  out_key_flags,
  input logic [7:0]                  out_key_modifier,
  input logic [7:0]                  out_buttons,
  input logic signed [7:0]           out_wheel,
  input logic signed [15:0]          out_pos_x,
  input logic signed [15:0]          out_pos_y
);

  // a new event only follows an accepted word
  a_evt_after_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("event without an accepted word");

  // keyboard and mouse fields never both carry data
  a_one_branch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_keycode | out_key_flags | out_key_modifier) == 8'd0)
               || ((out_buttons | out_wheel) == 8'd0 && (out_pos_x | out_pos_y) == 16'd0))
    else $error("keyboard and mouse fields both set");

  // held event's type and delay stay put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_delay) && $stable(out_event_type))
    else $error("stalled event changed");

  // nothing pending right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind framed_input_event_parser_top fiep_checker u_fiep_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for framed_input_event_parser_top: directed frames, then random
// framed traffic under several register settings and idle and stall patterns. Depends on fiep_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES = 11;
  localparam int STORE_LEN = FRAME_BYTES - 1;
  localparam int SETTLE_CYCLES = FRAME_BYTES + 4;
  localparam int DRAIN_LIMIT = 4000;
  localparam int PHASE_WORDS = 150;
  // address just past the last register; writes there must change nothing
  localparam int REG_NONE = 3;

  typedef struct packed {
    logic [7:0]       word;
    logic             typed;
    fiep_pkg::event_t ev;
  } dir_row_t;

  localparam fiep_pkg::event_t KBD_EXTREMES = '{event_type: 8'h01, delay: 16'hFF00,
                                                keycode: 8'h00, key_flags: 8'hFF,
                                                key_modifier: 8'h80, default: '0};
  localparam fiep_pkg::event_t MOUSE_EXTREMES = '{event_type: 8'h02, delay: 16'hFFFF,
                                                  buttons: 8'hFF, wheel: 8'sh80,
                                                  pos_x: 16'sh8000, pos_y: 16'sh7FFF,
                                                  default: '0};

  // default registers: head AA, tail 55, keyboard type 01
  localparam dir_row_t DIRECTED [28] = '{
    '{8'h00, 1'b0, '0},                      // dropped while hunting
    '{8'hAA, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h80, 1'b0, '0}, '{8'h11, 1'b0, '0}, '{8'h22, 1'b0, '0}, '{8'h33, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h55, 1'b1, KBD_EXTREMES},
    // bad tail with a head inside: realigns on the second AA, keeps six bytes
    '{8'hAA, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'hAA, 1'b0, '0}, '{8'h02, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h80, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h80, 1'b0, '0},
    '{8'hFF, 1'b0, '0}, '{8'h7F, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h55, 1'b1, MOUSE_EXTREMES}
  };

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_event_type;
  logic [15:0] out_delay;
  logic [7:0] out_keycode;
  logic [7:0] out_key_flags;
  logic [7:0] out_key_modifier;
  logic [7:0] out_buttons;
  logic signed [7:0] out_wheel;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic psel;
  logic penable;
  logic pwrite;
  logic [fiep_pkg::ADDR_W-1:0] paddr;
  logic [fiep_pkg::DATA_W-1:0] pwdata;
  logic [fiep_pkg::DATA_W-1:0] prdata;
  logic pready;

  // parser model state and register copies
  logic [7:0] rx_store [STORE_LEN];
  int unsigned rx_fill;
  logic [7:0] head_val;
  logic [7:0] tail_val;
  logic [7:0] kbd_val;

  fiep_pkg::event_t pending_events [$];
  fiep_pkg::event_t exp_ev;
  int fail_count = 0;
  int counted_words;
  int send_idle_pct = 0;
  int stall_pct = 0;

  framed_input_event_parser_top #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_type(out_event_type), .out_delay(out_delay),
    .out_keycode(out_keycode), .out_key_flags(out_key_flags),
    .out_key_modifier(out_key_modifier), .out_buttons(out_buttons),
    .out_wheel(out_wheel), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Advance the framer by one word; returns 1 when a frame closes with a good tail.
  function automatic bit frame_step(input logic [7:0] b, output fiep_pkg::event_t ev);
    logic [7:0] line [FRAME_BYTES];
    ev = '0;
    if (rx_fill == 0) begin
      if (b == head_val) begin
        rx_store[0] = b;
        rx_fill = 1;
      end
      return 1'b0;
    end
    if (rx_fill < STORE_LEN) begin
      rx_store[rx_fill] = b;
      rx_fill++;
      return 1'b0;
    end
    if (b == tail_val) begin
      ev.event_type = rx_store[1];
      ev.delay = {rx_store[9], rx_store[8]};
      if (rx_store[1] == kbd_val) begin
        ev.keycode = rx_store[2];
        ev.key_flags = rx_store[3];
        ev.key_modifier = rx_store[4];
      end else begin
        ev.buttons = rx_store[2];
        ev.wheel = rx_store[3];
        ev.pos_x = {rx_store[5], rx_store[4]};
        ev.pos_y = {rx_store[7], rx_store[6]};
      end
      rx_fill = 0;
      return 1'b1;
    end
    // wrong tail: realign on the earliest later head, or go back to hunting
    for (int i = 0; i < STORE_LEN; i++) line[i] = rx_store[i];
    line[FRAME_BYTES-1] = b;
    rx_fill = 0;
    for (int i = 1; i < FRAME_BYTES; i++) begin
      if (rx_fill == 0 && line[i] == head_val) begin
        for (int j = 0; j < FRAME_BYTES - i; j++) rx_store[j] = line[i + j];
        rx_fill = FRAME_BYTES - i;
      end
    end
    return 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_word(input logic [7:0] b, input bit typed = 1'b0,
                           input fiep_pkg::event_t typed_ev = '0);
    fiep_pkg::event_t ev;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rx_fill != 0 || b == head_val) counted_words++;
    if (frame_step(b, ev)) pending_events.push_back(typed ? typed_ev : ev);
  endtask

  task automatic write_reg(input int idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= fiep_pkg::ADDR_W'(idx * 4);
    // upper bits are junk; only the low byte may take effect
    pwdata <= ($urandom() & 32'hFFFF_FF00) | fiep_pkg::DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      fiep_pkg::REG_HEAD: head_val = val;
      fiep_pkg::REG_TAIL: tail_val = val;
      fiep_pkg::REG_KBD:  kbd_val = val;
      default: ;
    endcase
  endtask

  // Let every expected event drain, then allow a possible resync walk to finish.
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      fail_count++;
      pending_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_frame();
    int kind;
    int n;
    int roll;
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(1, 4);
      repeat (n) send_word(8'($urandom_range(255)));
    end else begin
      send_word(head_val);
      // a short run leaves a truncated frame that swallows what follows
      n = (kind < 22) ? $urandom_range(0, FRAME_BYTES - 3) : FRAME_BYTES - 2;
      for (int k = 0; k < n; k++) begin
        if (k == 0 && $urandom_range(1)) send_word(kbd_val);
        else if ($urandom_range(7) == 0) send_word(head_val);
        else send_word(8'($urandom_range(255)));
      end
      if (n == FRAME_BYTES - 2) begin
        roll = $urandom_range(9);
        if (roll < 8) send_word(tail_val);
        else if (roll == 8) send_word(head_val);
        else send_word(8'($urandom_range(255)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event, event_type %0h", out_event_type);
        fail_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        check_field("event_type", 16'(exp_ev.event_type), 16'(out_event_type));
        check_field("delay", exp_ev.delay, out_delay);
        check_field("keycode", 16'(exp_ev.keycode), 16'(out_keycode));
        check_field("key_flags", 16'(exp_ev.key_flags), 16'(out_key_flags));
        check_field("key_modifier", 16'(exp_ev.key_modifier), 16'(out_key_modifier));
        check_field("buttons", 16'(exp_ev.buttons), 16'(out_buttons));
        check_field("wheel", 16'(unsigned'(exp_ev.wheel)), 16'(unsigned'(out_wheel)));
        check_field("pos_x", exp_ev.pos_x, out_pos_x);
        check_field("pos_y", exp_ev.pos_y, out_pos_y);
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rx_byte <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rx_fill = 0;
    head_val = fiep_pkg::HEAD_RST;
    tail_val = fiep_pkg::TAIL_RST;
    kbd_val = fiep_pkg::KBD_RST;
    for (int i = 0; i < STORE_LEN; i++) rx_store[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].ev);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        settle();
        case (phase)
          1: begin
            write_reg(fiep_pkg::REG_HEAD, 8'h00);
            write_reg(fiep_pkg::REG_TAIL, 8'hFF);
            write_reg(fiep_pkg::REG_KBD, 8'h00);
          end
          2: begin
            write_reg(fiep_pkg::REG_HEAD, 8'hFF);
            write_reg(fiep_pkg::REG_TAIL, 8'h00);
            write_reg(fiep_pkg::REG_KBD, 8'hFF);
          end
          default: begin
            if (phase == 3) write_reg(REG_NONE, 8'($urandom_range(255)));
            write_reg(fiep_pkg::REG_HEAD, 8'($urandom_range(255)));
            write_reg(fiep_pkg::REG_TAIL, 8'($urandom_range(255)));
            write_reg(fiep_pkg::REG_KBD, 8'($urandom_range(255)));
          end
        endcase
      end
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      counted_words = 0;
      while (counted_words < PHASE_WORDS) send_random_frame();
    end

    settle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/fiep_pkg.sv
design/fiep_cell.sv
design/fiep_decode.sv
design/framed_input_event_parser_top.sv
design/fiep_checker.sv
tb/tb.sv
